FILE: sv/wvs_pkg.sv
// Package for the weekly valve schedule controller.
// Holds the shared constants, codes, beat layouts and the sequencer state type.
// No dependencies.
package wvs_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int ENTRY_W     = 15;
  localparam int DAY_MIN     = 1440;
  localparam int WEEK_MIN    = 7 * DAY_MIN;
  localparam int BEST_INIT   = 7 * DAY_MIN + 1;
  localparam logic [16:0] OVS_RESET = 17'd1800;

  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_ADD    = 3'd1;
  localparam logic [2:0] MODE_DELETE = 3'd2;
  localparam logic [2:0] MODE_CLEAR  = 3'd3;
  localparam logic [2:0] MODE_FOPEN  = 3'd4;
  localparam logic [2:0] MODE_FCLOSE = 3'd5;
  localparam logic [2:0] MODE_AUTO   = 3'd6;

  localparam logic [1:0] OVR_AUTO  = 2'd0;
  localparam logic [1:0] OVR_OPEN  = 2'd1;
  localparam logic [1:0] OVR_CLOSE = 2'd2;

  localparam logic [1:0] DRV_NONE  = 2'd0;
  localparam logic [1:0] DRV_OPEN  = 2'd1;
  localparam logic [1:0] DRV_CLOSE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic [1:0] REG_OVS = 2'd0;

  typedef struct packed {
    logic [5:0]  entry_index;
    logic        entry_open;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [2:0]  day;
    logic        time_valid;
    logic [31:0] now_seconds;
    logic [2:0]  mode;
  } item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] entry_count;
    logic [1:0]       override_mode;
    logic             valve_open;
    logic [1:0]       drive;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_TICK_DEC, S_RS_RD, S_RS_EV,
    S_FR_RD, S_FR_EV, S_DEL_RD, S_DEL_WR, S_FINISH
  } state_t;

endpackage

FILE: sv/wvs_evmem.sv
// Event table memory: one write port, one read port, registered read data.
// Depends on wvs_pkg for depth and entry width.
module wvs_evmem (
  input  logic                             clk,
  input  logic                             we,
  input  logic [wvs_pkg::ADDR_W-1:0]       waddr,
  input  logic [wvs_pkg::ENTRY_W-1:0]      wdata,
  input  logic                             re,
  input  logic [wvs_pkg::ADDR_W-1:0]       raddr,
  output logic [wvs_pkg::ENTRY_W-1:0]      rdata
);

  logic [wvs_pkg::ENTRY_W-1:0] mem [wvs_pkg::MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/weekly_valve_schedule_controller_core.sv
// Top level of the weekly valve schedule controller.
// Depends on wvs_pkg and wvs_evmem.
//
// Usage: one command beat enters on in_* (mode, clock, weekday, time, entry
// fields), and one or more result beats leave on out_*; out_tlast marks the
// final result of a command. The override duration register sits at cfg
// address 0. Commands are handled one at a time by a sequencer around the
// event table memory. A command without a scan goes from the dispatch state
// (and the tick decision state for a tick) to the finish state, which loads
// the output register and returns to idle. The restore scan on the first
// valid tick reads and evaluates each entry, a daily entry once per weekday;
// a minute change reads and checks each entry in turn. Delete shifts the
// table down, reading each entry above the deleted one and writing it one
// place lower. A new command is taken while the last result still waits in
// the output register. When the receiver stalls, the sequencer holds at the
// next step that needs the output register. Reset empties the table, closes
// the valve, returns to auto and sets the override duration to 1800 seconds.
module weekly_valve_schedule_controller_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // mode, now_seconds, time_valid, day, hour, minute, entry_open, entry_index
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // drive, valve_open, override_mode, entry_count, status
  output logic [15:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CW = wvs_pkg::CNT_W;
  localparam int AW = wvs_pkg::ADDR_W;

  wvs_pkg::state_t  state_r, state_nxt;
  wvs_pkg::item_t   item_r, item_nxt;
  wvs_pkg::result_t pend_r, pend_nxt, out_r, out_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  logic             out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [CW-1:0]    count_r, count_nxt, i_r, i_nxt;
  logic             valve_r, valve_nxt;
  logic [1:0]       ovr_r, ovr_nxt, status_r, status_nxt;
  logic [31:0]      deadline_r, deadline_nxt;
  logic [11:0]      prev_min_r, prev_min_nxt;
  logic             prev_valid_r, prev_valid_nxt;
  logic [16:0]      ovs_r;
  logic [2:0]       d_r, d_nxt;
  logic             first_r, first_nxt, act_r, act_nxt;
  logic signed [15:0] best_r, best_nxt;

  logic                     mem_we, mem_re;
  logic [AW-1:0]            mem_waddr, mem_raddr;
  logic [wvs_pkg::ENTRY_W-1:0] mem_wdata, mem_rdata;

  logic        out_free, out_load;
  logic [11:0] cur_min;
  logic [15:0] cur_week, sub_week;
  logic signed [15:0] ago_raw, ago;
  logic [2:0]  e_day, dcur;
  logic [4:0]  e_hour;
  logic [5:0]  e_min;
  logic        e_open, tgt, cfg_wr;

  wvs_evmem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_tready  = (state_r == wvs_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_r};
  assign out_tlast  = out_last_r;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & (cfg_paddr == wvs_pkg::REG_OVS);
  assign cfg_prdata = (cfg_paddr == wvs_pkg::REG_OVS) ? {15'b0, ovs_r} : 32'b0;
  assign out_free   = !out_valid_r || out_tready;

  assign e_day  = mem_rdata[2:0];
  assign e_hour = mem_rdata[7:3];
  assign e_min  = mem_rdata[13:8];
  assign e_open = mem_rdata[14];

  assign cur_min  = 12'(item_r.hour) * 12'd60 + 12'(item_r.minute);
  assign cur_week = 16'(item_r.day) * 16'(wvs_pkg::DAY_MIN) + 16'(cur_min);
  assign dcur     = first_r ? ((e_day == 3'd7) ? 3'd0 : e_day) : d_r;
  assign sub_week = 16'(dcur) * 16'(wvs_pkg::DAY_MIN) + 16'(e_hour) * 16'd60 + 16'(e_min);
  assign ago_raw  = $signed(cur_week - sub_week);
  assign ago      = (ago_raw < 0) ? ago_raw + 16'(wvs_pkg::WEEK_MIN) : ago_raw;

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    out_nxt        = out_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_load       = 1'b0;
    count_nxt      = count_r;
    i_nxt          = i_r;
    valve_nxt      = valve_r;
    ovr_nxt        = ovr_r;
    status_nxt     = status_r;
    deadline_nxt   = deadline_r;
    prev_min_nxt   = prev_min_r;
    prev_valid_nxt = prev_valid_r;
    d_nxt          = d_r;
    first_nxt      = first_r;
    act_nxt        = act_r;
    best_nxt       = best_r;
    mem_we         = 1'b0;
    mem_waddr      = i_r[AW-1:0];
    mem_wdata      = mem_rdata;
    mem_re         = 1'b0;
    mem_raddr      = i_r[AW-1:0];
    tgt            = 1'b0;

    unique case (state_r)
      wvs_pkg::S_IDLE: begin
        if (in_tvalid) begin
          item_nxt   = wvs_pkg::item_t'(in_tdata[56:0]);
          status_nxt = wvs_pkg::ST_OK;
          state_nxt  = wvs_pkg::S_DISPATCH;
        end
      end
      wvs_pkg::S_DISPATCH: begin
        state_nxt = wvs_pkg::S_FINISH;
        case (item_r.mode) inside
          wvs_pkg::MODE_TICK: begin
            if (ovr_r != wvs_pkg::OVR_AUTO && deadline_r != 32'd0 &&
                item_r.now_seconds >= deadline_r) begin
              ovr_nxt        = wvs_pkg::OVR_AUTO;
              deadline_nxt   = 32'd0;
              prev_valid_nxt = 1'b0;
            end
            state_nxt = wvs_pkg::S_TICK_DEC;
          end
          wvs_pkg::MODE_ADD: begin
            if (count_r >= CW'(wvs_pkg::MAX_ENTRIES)) begin
              status_nxt = wvs_pkg::ST_FULL;
            end else if (item_r.hour > 5'd23 || item_r.minute > 6'd59) begin
              status_nxt = wvs_pkg::ST_BAD;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = count_r[AW-1:0];
              mem_wdata = {item_r.entry_open, item_r.minute, item_r.hour, item_r.day};
              count_nxt = count_r + CW'(1);
            end
          end
          wvs_pkg::MODE_DELETE: begin
            if (item_r.entry_index >= 6'(count_r)) begin
              status_nxt = wvs_pkg::ST_RANGE;
            end else if (CW'(item_r.entry_index) + CW'(1) < count_r) begin
              i_nxt     = CW'(item_r.entry_index);
              state_nxt = wvs_pkg::S_DEL_RD;
            end else begin
              count_nxt = count_r - CW'(1);
            end
          end
          wvs_pkg::MODE_CLEAR: count_nxt = '0;
          wvs_pkg::MODE_FOPEN, wvs_pkg::MODE_FCLOSE: begin
            tgt          = (item_r.mode == wvs_pkg::MODE_FOPEN);
            ovr_nxt      = tgt ? wvs_pkg::OVR_OPEN : wvs_pkg::OVR_CLOSE;
            deadline_nxt = item_r.time_valid ? item_r.now_seconds + {15'b0, ovs_r} : 32'd0;
            if (valve_r != tgt) begin
              valve_nxt      = tgt;
              pend_valid_nxt = 1'b1;
              pend_nxt       = {wvs_pkg::ST_OK, count_r, ovr_nxt, tgt,
                                tgt ? wvs_pkg::DRV_OPEN : wvs_pkg::DRV_CLOSE};
            end
          end
          wvs_pkg::MODE_AUTO: begin
            ovr_nxt        = wvs_pkg::OVR_AUTO;
            deadline_nxt   = 32'd0;
            prev_valid_nxt = 1'b0;
          end
          default: ;
        endcase
      end
      wvs_pkg::S_TICK_DEC: begin
        state_nxt = wvs_pkg::S_FINISH;
        if (item_r.time_valid) begin
          if (!prev_valid_r) begin
            prev_min_nxt   = cur_min;
            prev_valid_nxt = 1'b1;
            if (ovr_r == wvs_pkg::OVR_AUTO && count_r != '0) begin
              i_nxt     = '0;
              best_nxt  = 16'(wvs_pkg::BEST_INIT);
              act_nxt   = 1'b0;
              state_nxt = wvs_pkg::S_RS_RD;
            end else begin
              tgt = (ovr_r == wvs_pkg::OVR_OPEN);
              if (valve_r != tgt) begin
                valve_nxt      = tgt;
                pend_valid_nxt = 1'b1;
                pend_nxt       = {wvs_pkg::ST_OK, count_r, ovr_r, tgt,
                                  tgt ? wvs_pkg::DRV_OPEN : wvs_pkg::DRV_CLOSE};
              end
            end
          end else if (cur_min != prev_min_r) begin
            prev_min_nxt = cur_min;
            if (ovr_r == wvs_pkg::OVR_AUTO && count_r != '0) begin
              i_nxt     = '0;
              state_nxt = wvs_pkg::S_FR_RD;
            end
          end
        end
      end
      wvs_pkg::S_RS_RD: begin
        mem_re    = 1'b1;
        first_nxt = 1'b1;
        state_nxt = wvs_pkg::S_RS_EV;
      end
      wvs_pkg::S_RS_EV: begin
        if (ago < best_r) begin
          best_nxt = ago;
          act_nxt  = e_open;
        end
        if (e_day == 3'd7 && dcur < 3'd6) begin
          d_nxt     = dcur + 3'd1;
          first_nxt = 1'b0;
        end else if (i_r + CW'(1) < count_r) begin
          i_nxt     = i_r + CW'(1);
          state_nxt = wvs_pkg::S_RS_RD;
        end else begin
          state_nxt = wvs_pkg::S_FINISH;
          if (valve_r != act_nxt) begin
            valve_nxt      = act_nxt;
            pend_valid_nxt = 1'b1;
            pend_nxt       = {wvs_pkg::ST_OK, count_r, ovr_r, act_nxt,
                              act_nxt ? wvs_pkg::DRV_OPEN : wvs_pkg::DRV_CLOSE};
          end
        end
      end
      wvs_pkg::S_FR_RD: begin
        mem_re    = 1'b1;
        state_nxt = wvs_pkg::S_FR_EV;
      end
      wvs_pkg::S_FR_EV: begin
        if (e_hour == item_r.hour && e_min == item_r.minute &&
            (e_day == 3'd7 || e_day == item_r.day) && e_open != valve_r) begin
          if (!pend_valid_r || out_free) begin
            if (pend_valid_r) begin
              out_load     = 1'b1;
              out_nxt      = pend_r;
              out_last_nxt = 1'b0;
            end
            valve_nxt      = e_open;
            pend_valid_nxt = 1'b1;
            pend_nxt       = {wvs_pkg::ST_OK, count_r, ovr_r, e_open,
                              e_open ? wvs_pkg::DRV_OPEN : wvs_pkg::DRV_CLOSE};
            state_nxt      = (i_r + CW'(1) < count_r) ? wvs_pkg::S_FR_RD : wvs_pkg::S_FINISH;
            i_nxt          = i_r + CW'(1);
          end
        end else begin
          state_nxt = (i_r + CW'(1) < count_r) ? wvs_pkg::S_FR_RD : wvs_pkg::S_FINISH;
          i_nxt     = i_r + CW'(1);
        end
      end
      wvs_pkg::S_DEL_RD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(i_r + CW'(1));
        state_nxt = wvs_pkg::S_DEL_WR;
      end
      wvs_pkg::S_DEL_WR: begin
        mem_we = 1'b1;
        i_nxt  = i_r + CW'(1);
        if (i_r + CW'(2) < count_r) begin
          state_nxt = wvs_pkg::S_DEL_RD;
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = wvs_pkg::S_FINISH;
        end
      end
      wvs_pkg::S_FINISH: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_last_nxt   = 1'b1;
          out_nxt        = pend_valid_r ? pend_r :
                           {status_r, count_r, ovr_r, valve_r, wvs_pkg::DRV_NONE};
          pend_valid_nxt = 1'b0;
          state_nxt      = wvs_pkg::S_IDLE;
        end
      end
      default: state_nxt = wvs_pkg::S_IDLE;
    endcase
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= wvs_pkg::S_IDLE;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      count_r      <= '0;
      valve_r      <= 1'b0;
      ovr_r        <= wvs_pkg::OVR_AUTO;
      deadline_r   <= 32'd0;
      prev_valid_r <= 1'b0;
      ovs_r        <= wvs_pkg::OVS_RESET;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      count_r      <= count_nxt;
      valve_r      <= valve_nxt;
      ovr_r        <= ovr_nxt;
      deadline_r   <= deadline_nxt;
      prev_valid_r <= prev_valid_nxt;
      if (cfg_wr) begin
        ovs_r <= cfg_pwdata[16:0];
      end
    end
    item_r     <= item_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
    i_r        <= i_nxt;
    status_r   <= status_nxt;
    prev_min_r <= prev_min_nxt;
    d_r        <= d_nxt;
    first_r    <= first_nxt;
    act_r      <= act_nxt;
    best_r     <= best_nxt;
  end

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(wvs_pkg::MAX_ENTRIES))
    else $error("event count beyond table depth");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wvs_pkg::S_IDLE) |-> !pend_valid_r)
    else $error("pending result left behind");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("output register overwritten");

  a_auto_deadline: assert property (@(posedge clk) disable iff (!rst_n)
    (ovr_r == wvs_pkg::OVR_AUTO) |-> (deadline_r == 32'd0))
    else $error("deadline set in auto mode");

endmodule

FILE: test/wvs_checker.sv
// Checker for the weekly valve schedule controller: watches the command, result
// and register channels, predicts every result beat and compares it field by field.
// Depends on wvs_pkg.
module wvs_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic       open;
  } sched_ev_t;

  typedef struct packed {
    wvs_pkg::result_t r;
    logic             last;
  } beat_t;

  sched_ev_t   sched [wvs_pkg::MAX_ENTRIES];
  int          sched_count;
  logic        valve;
  logic [1:0]  ovr;
  logic [31:0] deadline;
  int          prev_min;
  logic        prev_ok;
  logic [16:0] ovr_secs;
  beat_t       step_q[$];
  beat_t       expect_q[$];

  assign pending = expect_q.size();

  function automatic void note(logic [1:0] drv, logic [1:0] st);
    beat_t b;
    b.r.drive = drv;
    b.r.valve_open = valve;
    b.r.override_mode = ovr;
    b.r.entry_count = wvs_pkg::CNT_W'(sched_count);
    b.r.status = st;
    b.last = 1'b0;
    if (step_q.size() < 16) step_q.push_back(b);
    else step_q[15] = b;
  endfunction

  function automatic void set_valve(logic open);
    if (valve != open) begin
      valve = open;
      note(open ? wvs_pkg::DRV_OPEN : wvs_pkg::DRV_CLOSE, wvs_pkg::ST_OK);
    end
  endfunction

  function automatic void restore_state(int day, int hour, int minute);
    int cur, best, ago, em, d0, d1;
    logic act;
    best = wvs_pkg::BEST_INIT;
    act = 1'b0;
    if (ovr == wvs_pkg::OVR_OPEN) begin
      set_valve(1'b1);
      return;
    end
    if (ovr == wvs_pkg::OVR_CLOSE || sched_count == 0) begin
      set_valve(1'b0);
      return;
    end
    cur = day * wvs_pkg::DAY_MIN + hour * 60 + minute;
    for (int i = 0; i < sched_count; i++) begin
      em = sched[i].hour * 60 + sched[i].minute;
      d0 = (sched[i].day == 7) ? 0 : sched[i].day;
      d1 = (sched[i].day == 7) ? 6 : sched[i].day;
      for (int d = d0; d <= d1; d++) begin
        ago = cur - (d * wvs_pkg::DAY_MIN + em);
        if (ago < 0) ago += wvs_pkg::WEEK_MIN;
        if (ago < best) begin
          best = ago;
          act = sched[i].open;
        end
      end
    end
    set_valve(act);
  endfunction

  function automatic void predict(wvs_pkg::item_t it);
    logic [1:0] st;
    int cur;
    st = wvs_pkg::ST_OK;
    step_q.delete();
    case (it.mode) inside
      wvs_pkg::MODE_TICK: begin
        if (ovr != wvs_pkg::OVR_AUTO && deadline != 0 && it.now_seconds >= deadline) begin
          ovr = wvs_pkg::OVR_AUTO;
          deadline = 0;
          prev_ok = 1'b0;
        end
        if (it.time_valid) begin
          cur = it.hour * 60 + it.minute;
          if (!prev_ok) begin
            restore_state(it.day, it.hour, it.minute);
            prev_min = cur;
            prev_ok = 1'b1;
          end else if (cur != prev_min) begin
            prev_min = cur;
            if (ovr == wvs_pkg::OVR_AUTO) begin
              for (int i = 0; i < sched_count; i++) begin
                if (sched[i].hour == it.hour && sched[i].minute == it.minute &&
                    (sched[i].day == 7 || sched[i].day == it.day))
                  set_valve(sched[i].open);
              end
            end
          end
        end
      end
      wvs_pkg::MODE_ADD: begin
        if (sched_count >= wvs_pkg::MAX_ENTRIES) st = wvs_pkg::ST_FULL;
        else if (it.hour > 23 || it.minute > 59) st = wvs_pkg::ST_BAD;
        else begin
          sched[sched_count] = '{it.day, it.hour, it.minute, it.entry_open};
          sched_count++;
        end
      end
      wvs_pkg::MODE_DELETE: begin
        if (it.entry_index >= sched_count) st = wvs_pkg::ST_RANGE;
        else begin
          for (int i = it.entry_index; i + 1 < sched_count; i++) sched[i] = sched[i + 1];
          sched_count--;
        end
      end
      wvs_pkg::MODE_CLEAR: sched_count = 0;
      wvs_pkg::MODE_FOPEN, wvs_pkg::MODE_FCLOSE: begin
        ovr = (it.mode == wvs_pkg::MODE_FOPEN) ? wvs_pkg::OVR_OPEN : wvs_pkg::OVR_CLOSE;
        deadline = it.time_valid ? it.now_seconds + 32'(ovr_secs) : 32'd0;
        set_valve(it.mode == wvs_pkg::MODE_FOPEN);
      end
      wvs_pkg::MODE_AUTO: begin
        ovr = wvs_pkg::OVR_AUTO;
        deadline = 0;
        prev_ok = 1'b0;
      end
      default: ;
    endcase
    if (step_q.size() == 0) note(wvs_pkg::DRV_NONE, st);
    step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[k]) expect_q.push_back(step_q[k]);
  endfunction

  always @(posedge clk) begin
    beat_t b;
    wvs_pkg::result_t got;
    if (!rst_n) begin
      sched_count = 0;
      valve = 1'b0;
      ovr = wvs_pkg::OVR_AUTO;
      deadline = 0;
      prev_min = 0;
      prev_ok = 1'b0;
      ovr_secs = wvs_pkg::OVS_RESET;
      expect_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == wvs_pkg::REG_OVS)
        ovr_secs = cfg_pwdata[16:0];
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(wvs_pkg::result_t)-1:0];
        if (expect_q.size() == 0) begin
          $error("unexpected result beat %h", out_tdata);
          fail_count++;
        end else begin
          b = expect_q.pop_front();
          if (got.drive != b.r.drive) begin
            $error("drive: expected %0d, got %0d", b.r.drive, got.drive);
            fail_count++;
          end
          if (got.valve_open != b.r.valve_open) begin
            $error("valve_open: expected %0d, got %0d", b.r.valve_open, got.valve_open);
            fail_count++;
          end
          if (got.override_mode != b.r.override_mode) begin
            $error("override_mode: expected %0d, got %0d",
                   b.r.override_mode, got.override_mode);
            fail_count++;
          end
          if (got.entry_count != b.r.entry_count) begin
            $error("entry_count: expected %0d, got %0d", b.r.entry_count, got.entry_count);
            fail_count++;
          end
          if (got.status != b.r.status) begin
            $error("status: expected %0d, got %0d", b.r.status, got.status);
            fail_count++;
          end
          if (out_tlast != b.last) begin
            $error("last: expected %0d, got %0d", b.last, out_tlast);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) predict(in_tdata[$bits(wvs_pkg::item_t)-1:0]);
    end
  end
endmodule

FILE: test/tb.sv
// Testbench top for the weekly valve schedule controller: drives commands, register
// writes and result back-pressure, and reports the verdict from the checker.
// Depends on wvs_pkg, wvs_checker and weekly_valve_schedule_controller_core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] MODE_NOP = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count;
  int          pending;
  int          send_idle;
  int          recv_stall;
  logic [31:0] wall;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  weekly_valve_schedule_controller_core dut (.*);

  wvs_checker chk (.*);

  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_stall);

  initial begin
    #10ms;
    $display("tb: FAIL");
    $finish;
  end

  task automatic send(wvs_pkg::item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'b0, it};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_ovs(logic [16:0] secs);
    drain();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= wvs_pkg::REG_OVS;
    cfg_pwdata <= {15'b0, secs};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic wvs_pkg::item_t mk(logic [2:0] mode, logic [31:0] now, logic tv,
                                        logic [2:0] day, logic [4:0] hour,
                                        logic [5:0] minute, logic op, logic [5:0] idx);
    wvs_pkg::item_t it;
    it.mode = mode;
    it.now_seconds = now;
    it.time_valid = tv;
    it.day = day;
    it.hour = hour;
    it.minute = minute;
    it.entry_open = op;
    it.entry_index = idx;
    return it;
  endfunction

  function automatic wvs_pkg::item_t rand_item();
    wvs_pkg::item_t it;
    int pick;
    it = 57'({$urandom, $urandom});
    pick = $urandom_range(99);
    wall += $urandom_range(0, 1500);
    if ($urandom_range(19) == 0) wall = $urandom;
    it.now_seconds = wall;
    it.time_valid = ($urandom_range(9) != 0);
    if ($urandom_range(4) != 0) begin
      it.hour = 5'($urandom_range(0, 2));
      it.minute = 6'($urandom_range(0, 3));
    end
    if (pick < 45) it.mode = wvs_pkg::MODE_TICK;
    else if (pick < 70) begin
      it.mode = wvs_pkg::MODE_ADD;
      if ($urandom_range(9) != 0 && it.hour > 23) it.hour = 5'($urandom_range(0, 23));
      if ($urandom_range(9) != 0 && it.minute > 59) it.minute = 6'($urandom_range(0, 59));
    end else if (pick < 80) begin
      it.mode = wvs_pkg::MODE_DELETE;
      if ($urandom_range(3) != 0) it.entry_index = 6'($urandom_range(0, 17));
    end else if (pick < 83) it.mode = wvs_pkg::MODE_CLEAR;
    else if (pick < 89) it.mode = wvs_pkg::MODE_FOPEN;
    else if (pick < 95) it.mode = wvs_pkg::MODE_FCLOSE;
    else if (pick < 98) it.mode = wvs_pkg::MODE_AUTO;
    else it.mode = MODE_NOP;
    return it;
  endfunction

  initial begin
    wall = 32'd200000;
    send_idle = 0;
    recv_stall = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(mk(wvs_pkg::MODE_TICK, 32'd500, 1'b0, 3'd1, 5'd1, 6'd0, 1'b0, 6'd0));
    send(mk(wvs_pkg::MODE_TICK, 32'd200000, 1'b1, 3'd1, 5'd1, 6'd0, 1'b0, 6'd0));
    send(mk(wvs_pkg::MODE_ADD, 32'd0, 1'b1, 3'd2, 5'd24, 6'd0, 1'b1, 6'd0));
    send(mk(wvs_pkg::MODE_ADD, 32'd0, 1'b1, 3'd2, 5'd5, 6'd60, 1'b1, 6'd0));
    send(mk(wvs_pkg::MODE_ADD, 32'd0, 1'b1, 3'd7, 5'd23, 6'd59, 1'b1, 6'd0));
    send(mk(wvs_pkg::MODE_ADD, 32'd0, 1'b1, 3'd0, 5'd0, 6'd0, 1'b0, 6'd0));
    for (int i = 0; i < 14; i++)
      send(mk(wvs_pkg::MODE_ADD, 32'd0, 1'b1, 3'(i % 8), 5'd1, 6'(i % 3), 1'(i), 6'd0));
    send(mk(wvs_pkg::MODE_ADD, 32'd0, 1'b1, 3'd7, 5'd1, 6'd1, 1'b1, 6'd0));
    send(mk(wvs_pkg::MODE_DELETE, 32'd0, 1'b1, 3'd0, 5'd0, 6'd0, 1'b0, 6'd63));
    send(mk(wvs_pkg::MODE_DELETE, 32'd0, 1'b1, 3'd0, 5'd0, 6'd0, 1'b0, 6'd0));
    send(mk(wvs_pkg::MODE_TICK, 32'd200060, 1'b1, 3'd7, 5'd1, 6'd1, 1'b0, 6'd0));
    send(mk(wvs_pkg::MODE_TICK, 32'd200120, 1'b1, 3'd3, 5'd31, 6'd63, 1'b0, 6'd0));
    send(mk(wvs_pkg::MODE_FOPEN, 32'd5, 1'b0, 3'd0, 5'd0, 6'd0, 1'b0, 6'd0));
    send(mk(wvs_pkg::MODE_TICK, 32'hFFFF_FFFF, 1'b1, 3'd0, 5'd0, 6'd0, 1'b0, 6'd0));
    send(mk(wvs_pkg::MODE_AUTO, 32'd0, 1'b1, 3'd0, 5'd0, 6'd0, 1'b0, 6'd0));
    send(mk(wvs_pkg::MODE_FCLOSE, 32'hFFFF_FF00, 1'b1, 3'd0, 5'd0, 6'd0, 1'b0, 6'd0));
    send(mk(wvs_pkg::MODE_TICK, 32'd10, 1'b1, 3'd6, 5'd1, 6'd0, 1'b0, 6'd0));
    send(mk(wvs_pkg::MODE_TICK, 32'h0000_0800, 1'b1, 3'd6, 5'd1, 6'd2, 1'b0, 6'd0));
    send(mk(MODE_NOP, 32'd0, 1'b0, 3'd0, 5'd0, 6'd0, 1'b0, 6'd0));
    send(mk(wvs_pkg::MODE_CLEAR, 32'd0, 1'b0, 3'd0, 5'd0, 6'd0, 1'b0, 6'd0));

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_ovs(17'd1);
        1: write_ovs(17'd86400);
        2: write_ovs(17'h1FFFF);
        default: write_ovs(17'd0);
      endcase
      send_idle = (phase == 1) ? 77 : (phase == 3) ? 10 : 0;
      recv_stall = (phase == 2) ? 77 : (phase == 3) ? 10 : 0;
      for (int n = 0; n < 96; n++) begin
        if (n == 48) drain();
        send(rand_item());
      end
    end
    write_ovs(17'd60);
    for (int n = 0; n < 20; n++) send(rand_item());

    drain();
    if (fail_count == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule
